// ===== sv/dsa_pkg.sv =====
package dsa_pkg;

  localparam int COUNT_W     = 9;
  localparam int STRIDE_W    = 13;
  localparam int ADDR_W      = 48;
  localparam int INDEX_W     = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int WORD_W      = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam int MAX_SLOTS_DEF    = 256;
  localparam int ADDRESS_BITS_DEF = 48;

  localparam logic [COUNT_W-1:0]  SLOTS_RESET  = 9'd256;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GPU     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE = 3'd4;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FULL      = 2'd1,
    ST_FREED     = 2'd2,
    ST_IGNORED   = 2'd3
  } status_e;

  typedef struct packed {
    op_e                operation;
    logic [INDEX_W-1:0] free_index;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [INDEX_W-1:0] slot_index;
    logic [ADDR_W-1:0]  cpu_address;
    logic [ADDR_W-1:0]  gpu_address;
    logic [COUNT_W-1:0] used_count;
  } rsp_t;

  typedef struct packed {
    logic               is_free;
    logic               in_range;
    logic [INDEX_W-1:0] index;
  } cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  pool_n;
    logic [STRIDE_W-1:0] stride;
    logic [ADDR_W-1:0]   cpu_base;
    logic [ADDR_W-1:0]   gpu_base;
    logic                visible;
  } cfg_t;

  // slot indexes never reach past what a 9-bit slot count can address
  function automatic int slot_cap(input int max_slots);
    slot_cap = (max_slots > 511) ? 511 : max_slots;
  endfunction

endpackage

// ===== sv/dsa_front.sv =====
module dsa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dsa_pkg::req_t     in_data_i,
  input  logic [dsa_pkg::COUNT_W-1:0] pool_n_i,
  output logic              cmd_valid_o,
  output dsa_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);

  localparam int QPTR_W = (dsa_pkg::QUEUE_DEPTH > 1) ? $clog2(dsa_pkg::QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(dsa_pkg::QUEUE_DEPTH + 1);

  dsa_pkg::cmd_t      q_mem_q [dsa_pkg::QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               push;
  logic               pop;
  dsa_pkg::cmd_t      new_cmd;

  // classify
  always_comb begin
    new_cmd.is_free  = (in_data_i.operation == dsa_pkg::OP_FREE);
    new_cmd.in_range = ({1'b0, in_data_i.free_index} < pool_n_i);
    new_cmd.index    = in_data_i.free_index;
  end

  assign in_stall_o  = (cnt_q == QCNT_W'(dsa_pkg::QUEUE_DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(dsa_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(dsa_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

// ===== sv/dsa_back.sv =====
module dsa_back #(
  parameter int MAX_SLOTS    = dsa_pkg::MAX_SLOTS_DEF,
  parameter int ADDRESS_BITS = dsa_pkg::ADDRESS_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dsa_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  dsa_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dsa_pkg::rsp_t out_data_o
);

  localparam int DEPTH     = dsa_pkg::slot_cap(MAX_SLOTS);
  localparam int WW        = dsa_pkg::WORD_W;
  localparam int NUM_WORDS = (DEPTH + WW - 1) / WW;
  localparam int MAP_BITS  = NUM_WORDS * WW;
  localparam int SLOT_W    = $clog2(MAP_BITS);
  localparam int WSEL_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BSEL_W    = $clog2(WW);
  localparam int PROD_W    = SLOT_W + dsa_pkg::STRIDE_W;
  localparam int AW        = dsa_pkg::ADDR_W;
  localparam logic [AW-1:0] AddrMask =
    (ADDRESS_BITS >= AW) ? {AW{1'b1}} : ((AW'(1) << ADDRESS_BITS) - AW'(1));

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUMM = 3'd1;
  localparam logic [2:0] S_WORD = 3'd2;
  localparam logic [2:0] S_BIT  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_ADDR = 3'd5;

  logic [2:0]                   state_q, state_d;
  logic [MAP_BITS-1:0]          map_q, map_d;
  logic [dsa_pkg::COUNT_W-1:0]  count_q, count_d;
  logic                         out_valid_q, out_valid_d;
  dsa_pkg::rsp_t                out_data_q, out_data_d;
  logic [NUM_WORDS-1:0]         summary_q, summary_d;
  logic [WW-1:0]                word_q, word_d;
  logic [WSEL_W-1:0]            word_idx_q, word_idx_d;
  logic [SLOT_W-1:0]            slot_q, slot_d;
  logic [PROD_W-1:0]            prod_q, prod_d;

  logic [MAP_BITS-1:0]          lim;
  logic [NUM_WORDS-1:0]         summ_any;
  logic [WSEL_W-1:0]            word_pick;
  logic [BSEL_W-1:0]            bit_pick;
  logic [dsa_pkg::COUNT_W-1:0]  idx9;
  logic [SLOT_W-1:0]            free_slot;
  logic [WSEL_W+BSEL_W-1:0]     pick_cat;

  // slots below the pool size
  always_comb begin
    for (int g = 0; g < MAP_BITS; g++) begin
      lim[g] = (dsa_pkg::COUNT_W'(g) < cfg_i.pool_n);
    end
  end

  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      summ_any[w] = |(map_q[w*WW +: WW] & lim[w*WW +: WW]);
    end
  end

  // lowest word with a free slot
  always_comb begin
    word_pick = '0;
    for (int w = NUM_WORDS - 1; w >= 0; w--) begin
      if (summary_q[w]) begin
        word_pick = WSEL_W'(w);
      end
    end
  end

  // lowest free slot in the chosen word
  always_comb begin
    bit_pick = '0;
    for (int b = WW - 1; b >= 0; b--) begin
      if (word_q[b]) begin
        bit_pick = BSEL_W'(b);
      end
    end
  end

  assign idx9      = {1'b0, cmd_i.index};
  assign free_slot = idx9[SLOT_W-1:0];
  assign pick_cat  = {word_idx_q, bit_pick};

  always_comb begin
    state_d     = state_q;
    map_d       = map_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    summary_d   = summary_q;
    word_d      = word_q;
    word_idx_d  = word_idx_q;
    slot_d      = slot_q;
    prod_d      = prod_q;
    cmd_pop_o   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.is_free) begin
            out_valid_d            = 1'b1;
            out_data_d.slot_index  = '0;
            out_data_d.cpu_address = '0;
            out_data_d.gpu_address = '0;
            if (cmd_i.in_range && !map_q[free_slot]) begin
              map_d[free_slot]      = 1'b1;
              count_d               = count_q - 1'b1;
              out_data_d.status     = dsa_pkg::ST_FREED;
              out_data_d.used_count = count_q - 1'b1;
            end else begin
              out_data_d.status     = dsa_pkg::ST_IGNORED;
              out_data_d.used_count = count_q;
            end
          end else begin
            state_d = S_SUMM;
          end
        end
      end
      S_SUMM: begin
        summary_d = summ_any;
        state_d   = S_WORD;
      end
      S_WORD: begin
        if (summary_q == '0) begin
          out_valid_d            = 1'b1;
          out_data_d.status      = dsa_pkg::ST_FULL;
          out_data_d.slot_index  = '0;
          out_data_d.cpu_address = '0;
          out_data_d.gpu_address = '0;
          out_data_d.used_count  = count_q;
          state_d                = S_IDLE;
        end else begin
          word_idx_d = word_pick;
          word_d     = map_q[word_pick*WW +: WW] & lim[word_pick*WW +: WW];
          state_d    = S_BIT;
        end
      end
      S_BIT: begin
        slot_d                   = pick_cat[SLOT_W-1:0];
        map_d[pick_cat[SLOT_W-1:0]] = 1'b0;
        count_d                  = count_q + 1'b1;
        state_d                  = S_MUL;
      end
      S_MUL: begin
        prod_d  = PROD_W'(slot_q) * PROD_W'(cfg_i.stride);
        state_d = S_ADDR;
      end
      S_ADDR: begin
        out_valid_d            = 1'b1;
        out_data_d.status      = dsa_pkg::ST_ALLOCATED;
        out_data_d.slot_index  = dsa_pkg::INDEX_W'(slot_q);
        out_data_d.cpu_address = (cfg_i.cpu_base + AW'(prod_q)) & AddrMask;
        out_data_d.gpu_address = cfg_i.visible ?
                                 ((cfg_i.gpu_base + AW'(prod_q)) & AddrMask) : '0;
        out_data_d.used_count  = count_q;
        state_d                = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      map_q       <= '1;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      map_q       <= map_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    summary_q  <= summary_d;
    word_q     <= word_d;
    word_idx_q <= word_idx_d;
    slot_q     <= slot_d;
    prod_q     <= prod_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/descriptor_slot_allocator.sv =====
// channel   direction  handshake               payload
// in        input      in_valid_i / in_stall_o  dsa_pkg::req_t in_data_i
// out       output     out_valid_o / out_stall_i dsa_pkg::rsp_t out_data_o
// cfg       input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// a transfer enters a two-entry command queue in the cycle it is accepted
// free requests complete in the dequeue step of the execution unit, allocations take six steps:
// dequeue, bitmap summary, word pick, slot pick, index times stride, base add
// the slot bitmap sits in flip-flops that reset sets to all free, no clearing pass
// the result register holds a stalled result; the queue keeps taking input until both entries fill
module descriptor_slot_allocator #(
  parameter int MAX_SLOTS    = dsa_pkg::MAX_SLOTS_DEF,
  parameter int ADDRESS_BITS = dsa_pkg::ADDRESS_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  dsa_pkg::req_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dsa_pkg::rsp_t                     out_data_o,
  input  logic                              cfg_we_i,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dsa_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int DEPTH = dsa_pkg::slot_cap(MAX_SLOTS);

  logic [dsa_pkg::COUNT_W-1:0]  slots_q;
  logic [dsa_pkg::STRIDE_W-1:0] stride_q;
  logic [dsa_pkg::ADDR_W-1:0]   cpu_base_q;
  logic [dsa_pkg::ADDR_W-1:0]   gpu_base_q;
  logic                         visible_q;
  logic [dsa_pkg::COUNT_W-1:0]  pool_n;
  dsa_pkg::cfg_t                cfg;
  logic                         cmd_valid;
  dsa_pkg::cmd_t                cmd;
  logic                         cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q    <= dsa_pkg::SLOTS_RESET;
      stride_q   <= dsa_pkg::STRIDE_RESET;
      cpu_base_q <= '0;
      gpu_base_q <= '0;
      visible_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dsa_pkg::CFG_SLOTS:   slots_q    <= cfg_data_i[dsa_pkg::COUNT_W-1:0];
        dsa_pkg::CFG_STRIDE:  stride_q   <= cfg_data_i[dsa_pkg::STRIDE_W-1:0];
        dsa_pkg::CFG_CPU:     cpu_base_q <= cfg_data_i[dsa_pkg::ADDR_W-1:0];
        dsa_pkg::CFG_GPU:     gpu_base_q <= cfg_data_i[dsa_pkg::ADDR_W-1:0];
        dsa_pkg::CFG_VISIBLE: visible_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // slot count above the built depth acts as the depth
  assign pool_n = (slots_q > dsa_pkg::COUNT_W'(DEPTH)) ? dsa_pkg::COUNT_W'(DEPTH) : slots_q;

  always_comb begin
    cfg.pool_n   = pool_n;
    cfg.stride   = stride_q;
    cfg.cpu_base = cpu_base_q;
    cfg.gpu_base = gpu_base_q;
    cfg.visible  = visible_q;
  end

  dsa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .pool_n_i    (pool_n),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  dsa_back #(
    .MAX_SLOTS    (MAX_SLOTS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import dsa_pkg::*;

  localparam int LIMIT = 400_000;

  class slot_scoreboard;
    logic [COUNT_W-1:0]  pool_n;
    logic [STRIDE_W-1:0] stride;
    logic [ADDR_W-1:0]   cpu_base;
    logic [ADDR_W-1:0]   gpu_base;
    logic                visible;
    bit                  taken[MAX_SLOTS_DEF];
    logic [COUNT_W-1:0]  taken_total;
    rsp_t                expected_q[$];
    int                  errors;
    int                  hits[4];

    function new();
      pool_n      = SLOTS_RESET;
      stride      = STRIDE_RESET;
      cpu_base    = '0;
      gpu_base    = '0;
      visible     = 1'b0;
      taken_total = '0;
      errors      = 0;
      foreach (taken[i]) taken[i] = 1'b0;
      foreach (hits[i]) hits[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_SLOTS:   pool_n = d[COUNT_W-1:0];
        CFG_STRIDE:  stride = d[STRIDE_W-1:0];
        CFG_CPU:     cpu_base = d[ADDR_W-1:0];
        CFG_GPU:     gpu_base = d[ADDR_W-1:0];
        CFG_VISIBLE: visible = d[0];
        default: ;
      endcase
    endfunction

    function logic [ADDR_W-1:0] slot_addr(logic [ADDR_W-1:0] base, int idx);
      logic [63:0] sum;
      sum = 64'(base) + 64'(idx) * 64'(stride);
      return sum[ADDR_W-1:0];
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int   n;
      e = '0;
      n = (pool_n > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(pool_n);
      if (r.operation == OP_ALLOC) begin
        e.status = ST_FULL;
        for (int i = 0; i < n; i++) begin
          if (!taken[i]) begin
            taken[i]      = 1'b1;
            taken_total   = taken_total + 1'b1;
            e.status      = ST_ALLOCATED;
            e.slot_index  = INDEX_W'(i);
            e.cpu_address = slot_addr(cpu_base, i);
            if (visible) e.gpu_address = slot_addr(gpu_base, i);
            break;
          end
        end
      end else begin
        e.status = ST_IGNORED;
        if (int'(r.free_index) < n && taken[r.free_index]) begin
          taken[r.free_index] = 1'b0;
          taken_total         = taken_total - 1'b1;
          e.status            = ST_FREED;
        end
      end
      e.used_count = taken_total;
      expected_q.push_back(e);
    endfunction

    function void match(string field, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, field, e, a);
      end
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending expected none actual %h", $time, a);
        return;
      end
      e = expected_q.pop_front();
      match("status", 64'(e.status), 64'(a.status));
      match("slot_index", 64'(e.slot_index), 64'(a.slot_index));
      match("cpu_address", 64'(e.cpu_address), 64'(a.cpu_address));
      match("gpu_address", 64'(e.gpu_address), 64'(a.gpu_address));
      match("used_count", 64'(e.used_count), 64'(a.used_count));
      hits[int'(a.status)]++;
    endfunction

    function int random_taken_slot();
      int list[$];
      foreach (taken[i]) if (taken[i]) list.push_back(i);
      if (list.size() == 0) return -1;
      return list[$urandom_range(list.size() - 1)];
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  req_t                  in_data;
  logic                  out_valid;
  logic                  out_stall;
  rsp_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  slot_scoreboard sb = new();
  int cycles;
  int results_seen;
  int hold_left;
  bit hold_done;
  int rand_sent;
  int settings_used;

  descriptor_slot_allocator u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("descriptor_slot_allocator regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off, and a calm stretch
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
      results_seen++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 250) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_stall <= 1'b1;
    end else if (results_seen >= 450 && results_seen < 560) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 13);
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[ADDR_W-1:0];
  endfunction

  function automatic req_t make_req(op_e op, logic [INDEX_W-1:0] idx);
    req_t r;
    r.operation  = op;
    r.free_index = idx;
    return r;
  endfunction

  function automatic req_t next_request(int alloc_pct);
    req_t r;
    int   s;
    r.operation  = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE;
    r.free_index = INDEX_W'($urandom());
    if (r.operation == OP_FREE && $urandom_range(99) < 70) begin
      s = sb.random_taken_slot();
      if (s >= 0) r.free_index = INDEX_W'(s);
    end
    return r;
  endfunction

  task automatic send(req_t r, bit may_idle);
    if (may_idle && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic configure(logic [COUNT_W-1:0] slots, logic [STRIDE_W-1:0] stride,
                           logic [ADDR_W-1:0] cpu, logic [ADDR_W-1:0] gpu, logic vis);
    cfg_write(CFG_SLOTS, CFG_DATA_W'(slots));
    cfg_write(CFG_STRIDE, CFG_DATA_W'(stride));
    cfg_write(CFG_CPU, cpu);
    cfg_write(CFG_GPU, gpu);
    cfg_write(CFG_VISIBLE, CFG_DATA_W'(vis));
    // unused register indexes must be ignored
    for (int k = int'(CFG_VISIBLE) + 1; k < (1 << CFG_IDX_W); k++)
      cfg_write(CFG_IDX_W'(k), rand_addr());
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic run_random(int count, int alloc_pct);
    repeat (count) begin
      send(next_request(alloc_pct), !(rand_sent >= 450 && rand_sent < 560));
      rand_sent++;
    end
    drain();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings
    send(make_req(OP_ALLOC, 8'h00), 1'b0);
    send(make_req(OP_ALLOC, 8'hff), 1'b0);
    send(make_req(OP_ALLOC, 8'h00), 1'b0);
    send(make_req(OP_FREE, 8'd1), 1'b0);
    send(make_req(OP_FREE, 8'd1), 1'b0);
    send(make_req(OP_ALLOC, 8'h00), 1'b0);
    send(make_req(OP_FREE, 8'hff), 1'b0);
    send(make_req(OP_FREE, 8'd0), 1'b0);
    drain();

    // tiny pool, widest stride, address wrap
    configure(9'd2, 13'h1fff, 48'hffff_ffff_ffff, 48'haaaa_aaaa_aaaa, 1'b1);
    send(make_req(OP_ALLOC, 8'h00), 1'b0);
    send(make_req(OP_ALLOC, 8'h00), 1'b0);
    send(make_req(OP_FREE, 8'd2), 1'b0);
    send(make_req(OP_FREE, 8'd1), 1'b0);
    send(make_req(OP_ALLOC, 8'h00), 1'b0);
    drain();

    // empty pool
    configure(9'd0, 13'd1, 48'h0, 48'h5555_5555_5555, 1'b1);
    send(make_req(OP_ALLOC, 8'h00), 1'b0);
    send(make_req(OP_FREE, 8'd0), 1'b0);
    drain();

    // slot count above depth
    configure(9'h1ff, 13'd4096, 48'h0123_4567_89ab, 48'hffff_ffff_ffff, 1'b1);
    send(make_req(OP_ALLOC, 8'h00), 1'b0);
    send(make_req(OP_FREE, 8'd2), 1'b0);
    send(make_req(OP_ALLOC, 8'h00), 1'b0);
    send(make_req(OP_FREE, 8'd3), 1'b0);
    drain();

    configure(9'd4, 13'd32, rand_addr(), rand_addr(), 1'b0);
    send(make_req(OP_ALLOC, 8'h00), 1'b0);
    send(make_req(OP_ALLOC, 8'h00), 1'b0);
    send(make_req(OP_FREE, 8'hff), 1'b0);
    drain();

    configure(COUNT_W'($urandom_range(1, 16)), STRIDE_W'($urandom_range(1, 8191)),
              rand_addr(), rand_addr(), 1'b1);
    run_random(120, 55);
    configure(9'd256, 13'd4096, rand_addr(), rand_addr(), 1'b0);
    run_random(320, 85);
    configure(9'd5, 13'h1fff, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 1'b1);
    run_random(110, 50);
    configure(COUNT_W'($urandom_range(0, 511)), STRIDE_W'($urandom_range(1, 8191)),
              rand_addr(), rand_addr(), 1'($urandom()));
    run_random(200, 60);

    $display("exercised %0d requests under %0d register settings", results_seen,
             settings_used);
    $display("outcomes: %0d allocated, %0d full, %0d freed, %0d ignored",
             sb.hits[ST_ALLOCATED], sb.hits[ST_FULL], sb.hits[ST_FREED],
             sb.hits[ST_IGNORED]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("descriptor_slot_allocator regression: pass");
    end else begin
      $display("descriptor_slot_allocator regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dsa_pkg.sv
sv/dsa_front.sv
sv/dsa_back.sv
sv/descriptor_slot_allocator.sv
test/tb.sv
